FILE: rtl/assert_macros.svh
// Assertion helpers used by ordered_pair_table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/opt_pkg.sv
`default_nettype none

package opt_pkg;

    localparam int DEPTH = 16;

    typedef enum logic [2:0] {
        REQ_APPEND      = 3'd0,
        REQ_FIND_FIRST  = 3'd1,
        REQ_FIND_SECOND = 3'd2,
        REQ_DEL_FIRST   = 3'd3,
        REQ_DEL_SECOND  = 3'd4
    } opt_req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } opt_status_t;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } opt_pair_t;

    typedef struct packed {
        logic       append;
        logic       remove;
        logic       by_second;
        logic [7:0] key;
        opt_pair_t  pair;
    } opt_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/opt_cell.sv
`default_nettype none

module opt_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire opt_pkg::opt_cmd_t cmd,
    input  wire logic              prev_valid,
    input  wire logic              next_valid,
    input  wire opt_pkg::opt_pair_t next_pair,
    input  wire logic              hit_in,
    input  wire opt_pkg::opt_pair_t res_in,
    output logic                   hit_out,
    output opt_pkg::opt_pair_t     res_out,
    output logic                   valid,
    output opt_pkg::opt_pair_t     pair
);
    import opt_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    opt_pair_t pair_reg;
    opt_pair_t pair_next;
    logic      match;

    assign match = valid_reg &&
        ((cmd.by_second ? pair_reg.second : pair_reg.first) == cmd.key);
    assign hit_out = hit_in || match;
    assign res_out = (match && !hit_in) ? pair_reg : res_in;
    assign valid = valid_reg;
    assign pair = pair_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pair_next = pair_reg;
        if (cmd.append && !valid_reg && prev_valid)
        begin
            valid_next = 1'b1;
            pair_next = cmd.pair;
        end
        else if (cmd.remove && hit_out)
        begin
            valid_next = next_valid;
            pair_next = next_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pair_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pair_reg <= pair_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ordered_pair_table.sv
// A result is registered, valid in the cycle after its request transfer.
// Throughput: one request per cycle unless a held result stalls input; the
// match and priority chain that runs through every cell in a single cycle
// sets the clock period. Reset empties every cell, drops a pending result.
`default_nettype none

module ordered_pair_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // key_second [15:8], key_first [7:0]
    input  wire logic [2:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // out_second [15:8], out_first [7:0]
    output logic [1:0]       m_axis_tuser   // status
);
    import opt_pkg::*;

    `include "assert_macros.svh"

    logic        accept;
    logic        is_append;
    logic        is_find;
    logic        is_remove;
    logic        by_second;
    opt_cmd_t    cmd;
    logic [DEPTH:0] hit_chain;
    opt_pair_t   res_chain [DEPTH+1];
    logic [DEPTH-1:0] valid_vec;
    opt_pair_t   pair_vec [DEPTH];

    logic        out_valid_reg;
    logic        out_valid_next;
    opt_status_t out_status_reg;
    opt_status_t out_status_next;
    opt_pair_t   out_pair_reg;
    opt_pair_t   out_pair_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        is_append = 1'b0;
        is_find = 1'b0;
        is_remove = 1'b0;
        by_second = 1'b0;
        case (s_axis_tuser)
            REQ_APPEND:      is_append = 1'b1;
            REQ_FIND_FIRST:  is_find = 1'b1;
            REQ_FIND_SECOND:
            begin
                is_find = 1'b1;
                by_second = 1'b1;
            end
            REQ_DEL_FIRST:   is_remove = 1'b1;
            REQ_DEL_SECOND:
            begin
                is_remove = 1'b1;
                by_second = 1'b1;
            end
            default:         is_find = 1'b0;
        endcase
    end

    assign cmd.append = accept && is_append;
    assign cmd.remove = accept && is_remove;
    assign cmd.by_second = by_second;
    assign cmd.key = by_second ? s_axis_tdata[15:8] : s_axis_tdata[7:0];
    assign cmd.pair.first = s_axis_tdata[7:0];
    assign cmd.pair.second = s_axis_tdata[15:8];

    assign hit_chain[0] = 1'b0;
    assign res_chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic      prev_v;
        logic      next_v;
        opt_pair_t next_p;

        if (i == 0)
        begin : g_head
            assign prev_v = 1'b1;
        end
        else
        begin : g_body
            assign prev_v = valid_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_v = 1'b0;
            assign next_p = '0;
        end
        else
        begin : g_inner
            assign next_v = valid_vec[i+1];
            assign next_p = pair_vec[i+1];
        end

        opt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_pair  (next_p),
            .hit_in     (hit_chain[i]),
            .res_in     (res_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .res_out    (res_chain[i+1]),
            .valid      (valid_vec[i]),
            .pair       (pair_vec[i])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_status_next = out_status_reg;
        out_pair_next = out_pair_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (is_append)
            begin
                out_status_next = valid_vec[DEPTH-1] ? ST_FULL : ST_OK;
                out_pair_next = cmd.pair;
            end
            else if ((is_find || is_remove) && hit_chain[DEPTH])
            begin
                out_status_next = ST_OK;
                out_pair_next = res_chain[DEPTH];
            end
            else
            begin
                out_status_next = ST_MISS;
                out_pair_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_status_reg <= ST_MISS;
            out_pair_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_status_reg <= out_status_next;
            out_pair_reg <= out_pair_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser = out_status_reg;
    assign m_axis_tdata = {out_pair_reg.second, out_pair_reg.first};

    `ASSERT_IMPLIES(a_valid_prefix, clk, rst_n, 1'b1,
        ((valid_vec >> 1) & ~valid_vec) == '0, "occupied cells are not a prefix")
    `ASSERT_NEXT(a_remove_shrinks, clk, rst_n, cmd.remove && hit_chain[DEPTH],
        $countones(valid_vec) == $countones($past(valid_vec)) - 1,
        "a removal did not free exactly one cell")
    `ASSERT_NEXT(a_append_grows, clk, rst_n, cmd.append && !valid_vec[DEPTH-1],
        $countones(valid_vec) == $countones($past(valid_vec)) + 1,
        "an append did not fill exactly one cell")
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == ST_MISS), m_axis_tdata == '0,
        "a miss carries a nonzero pair")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import opt_pkg::*;

    localparam logic [2:0] REQ_UNUSED = 3'd5;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        opt_status_t status;
        logic [7:0]  first;
        logic [7:0]  second;
    } table_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [7:0]    shadow_first [DEPTH];
    logic [7:0]    shadow_second [DEPTH];
    int            shadow_count = 0;
    table_answer_t expected_answers [$];
    int            error_count = 0;
    int            quiet_cycles = 0;
    bit            idle_on = 1'b1;
    bit            hold_results = 1'b0;

    ordered_pair_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Applies one request to the shadow table and queues the answer it must give.
    function automatic void apply_to_table(input logic [2:0] kind, input logic [7:0] kf,
                                           input logic [7:0] ks);
        table_answer_t ans;
        logic          by_second;
        logic [7:0]    key;
        int            hit;
        ans.status = ST_MISS;
        ans.first = 8'h00;
        ans.second = 8'h00;
        hit = -1;
        if (kind == REQ_APPEND)
        begin
            ans.first = kf;
            ans.second = ks;
            if (shadow_count < DEPTH)
            begin
                shadow_first[shadow_count] = kf;
                shadow_second[shadow_count] = ks;
                shadow_count++;
                ans.status = ST_OK;
            end
            else
                ans.status = ST_FULL;
        end
        else if (kind <= REQ_DEL_SECOND)
        begin
            by_second = (kind == REQ_FIND_SECOND) || (kind == REQ_DEL_SECOND);
            key = by_second ? ks : kf;
            for (int i = 0; i < shadow_count && hit < 0; i++)
                if ((by_second ? shadow_second[i] : shadow_first[i]) == key)
                    hit = i;
            if (hit >= 0)
            begin
                ans.status = ST_OK;
                ans.first = shadow_first[hit];
                ans.second = shadow_second[hit];
                if (kind == REQ_DEL_FIRST || kind == REQ_DEL_SECOND)
                begin
                    for (int i = hit; i + 1 < shadow_count; i++)
                    begin
                        shadow_first[i] = shadow_first[i + 1];
                        shadow_second[i] = shadow_second[i + 1];
                    end
                    shadow_first[shadow_count - 1] = 8'h00;
                    shadow_second[shadow_count - 1] = 8'h00;
                    shadow_count--;
                end
            end
        end
        expected_answers.push_back(ans);
    endfunction

    task automatic send_request(input logic [2:0] kind, input logic [7:0] kf,
                                input logic [7:0] ks);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ks, kf};
        s_axis_tuser <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_to_table(kind, kf, ks);
    endtask

    function automatic logic [7:0] pick_key(input bit by_second);
        int idx;
        if (shadow_count > 0 && $urandom_range(0, 9) < 6)
        begin
            idx = $urandom_range(0, shadow_count - 1);
            return by_second ? shadow_second[idx] : shadow_first[idx];
        end
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_request(input int append_pct);
        int         r;
        logic [2:0] kind;
        logic [7:0] kf;
        logic [7:0] ks;
        r = $urandom_range(0, 99);
        kf = 8'($urandom_range(0, 255));
        ks = 8'($urandom_range(0, 255));
        if (r < 3)
            kind = 3'(int'(REQ_UNUSED) + $urandom_range(0, 2));
        else if (r < 3 + append_pct)
        begin
            kind = REQ_APPEND;
            if ($urandom_range(0, 1) == 1)
            begin
                kf = 8'($urandom_range(0, 15));
                ks = 8'($urandom_range(0, 15));
            end
        end
        else
        begin
            kind = 3'(int'(REQ_FIND_FIRST) + $urandom_range(0, 3));
            if (kind == REQ_FIND_SECOND || kind == REQ_DEL_SECOND)
                ks = pick_key(1'b1);
            else
                kf = pick_key(1'b0);
        end
        send_request(kind, kf, ks);
    endtask

    task automatic test_empty_table();
        send_request(REQ_FIND_FIRST, 8'h00, 8'h00);
        send_request(REQ_FIND_SECOND, 8'hFF, 8'hFF);
        send_request(REQ_DEL_FIRST, 8'hFF, 8'h00);
        send_request(REQ_DEL_SECOND, 8'h00, 8'hFF);
    endtask

    task automatic test_fill_to_full();
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                send_request(REQ_APPEND, 8'h00, 8'hFF);
            else if (i == DEPTH - 1)
                send_request(REQ_APPEND, 8'hFF, 8'h00);
            else
                send_request(REQ_APPEND, 8'(8'h10 * (i % 8)), 8'(8'h11 * i));
        end
        send_request(REQ_APPEND, 8'hA5, 8'h5A);
    endtask

    task automatic test_match_earliest();
        send_request(REQ_FIND_FIRST, 8'h10, 8'h00);
        send_request(REQ_FIND_SECOND, 8'h00, 8'h00);
        send_request(REQ_DEL_FIRST, 8'h20, 8'h00);
        send_request(REQ_DEL_SECOND, 8'h00, 8'hFF);
    endtask

    task automatic test_random_mix(input int count);
        int append_pct;
        append_pct = 40;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                append_pct = $urandom_range(15, 70);
            send_random_request(append_pct);
        end
    endtask

    task automatic test_result_backpressure();
        hold_results = 1'b1;
        for (int n = 0; n < 60; n++)
            send_random_request(45);
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_first[i] = 8'h00;
            shadow_second[i] = 8'h00;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_fill_to_full();
        test_match_earliest();
        test_random_mix(1200);
        test_result_backpressure();
        idle_on = 1'b0;
        test_random_mix(500);
        s_axis_tvalid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_answers.size() != 0)
            report_mismatch("answers left over", 16'(expected_answers.size()), 16'h0);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    always
    begin : result_sink
        @(posedge clk);
        if (hold_results)
        begin
            m_axis_tready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++)
                @(posedge clk);
            hold_results = 1'b0;
            m_axis_tready <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : answer_check
        table_answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_answers.size() == 0)
                report_mismatch("unexpected answer", {m_axis_tuser, m_axis_tdata[13:0]}, 16'h0);
            else
            begin
                want = expected_answers.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 16'(m_axis_tuser), 16'(want.status));
                if (m_axis_tdata[7:0] !== want.first)
                    report_mismatch("out_first", 16'(m_axis_tdata[7:0]), 16'(want.first));
                if (m_axis_tdata[15:8] !== want.second)
                    report_mismatch("out_second", 16'(m_axis_tdata[15:8]), 16'(want.second));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
